### design/kvx_pkg.sv
// Shared types and constants for the key=value line field extractor.
// No dependencies; used by kvx_scan, the top level and the checker.
`timescale 1ns / 1ps

package kvx_pkg;

	localparam int LEN_W     = 6;
	localparam int CFG_IDX_W = 3;

	localparam logic [4:0] KEY_MAX = 5'd16;

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_NOT_FOUND = 2'd1;
	localparam logic [1:0] ST_DUPLICATE = 2'd2;
	localparam logic [1:0] ST_TOO_LONG  = 2'd3;
	localparam logic [1:0] ERR_NONE     = 2'd0;

	localparam logic [7:0] CH_NUL = 8'h00;
	localparam logic [7:0] CH_LF  = 8'h0A;
	localparam logic [7:0] CH_CR  = 8'h0D;
	localparam logic [7:0] CH_EQ  = 8'h3D;

	localparam logic [CFG_IDX_W-1:0] REG_KEY_LOW  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_KEY_HIGH = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_KEY_LEN  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_STRICT   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_CAPACITY = 3'd4;

	typedef enum logic [2:0] {
		S_SCAN   = 3'b001,
		S_EMIT   = 3'b010,
		S_REPORT = 3'b100
	} state_t;

	typedef struct packed {
		logic [63:0] key_low;
		logic [63:0] key_high;
		logic [4:0]  key_len;
		logic        strict;
		logic [6:0]  capacity;
	} cfg_t;

	typedef struct packed {
		logic [7:0] text_byte;
		logic       byte_valid;
		logic       end_of_text;
	} item_t;

	typedef struct packed {
		logic             en;
		logic [LEN_W-1:0] addr;
		logic [7:0]       data;
	} wr_t;

	typedef struct packed {
		logic [1:0]       err;
		logic             found;
		logic [LEN_W-1:0] kept;
	} run_t;

endpackage

### design/key_value_line_field_extractor.sv
// Top level of the key=value line field extractor: config registers, value store,
// result sequencer and output register. Depends on kvx_pkg and kvx_scan.
`timescale 1ns / 1ps

// Text is taken one byte item per cycle. A byte that commits both a held CR
// and itself stalls the input while its second write is made, since the value
// store has a single write port. At end of text the input stalls: a status
// result passes through the report state into the output register; a value
// item is read from the value store into a read register and then loaded into
// the output register, the first read waiting for any such second write, and
// further value items follow one per cycle while the output is not stalled.
// Text is taken again from the cycle after the final result enters the output
// register, so the next run overlaps the unloading of that result.
module key_value_line_field_extractor #(
	parameter int VALUE_DEPTH = 64
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [kvx_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [63:0]                   cfg_data,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [7:0]                    text_byte,
	input  logic                          byte_valid,
	input  logic                          end_of_text,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [1:0]                    status,
	output logic [7:0]                    value_byte,
	output logic [kvx_pkg::LEN_W-1:0]     value_len,
	output logic                          last_result
);

	localparam int AW = (VALUE_DEPTH > 1) ? $clog2(VALUE_DEPTH) : 1;

	kvx_pkg::cfg_t   cfg_q;
	kvx_pkg::item_t  item;
	kvx_pkg::wr_t    wr;
	kvx_pkg::run_t   run;
	kvx_pkg::state_t state_q;
	logic            scan_busy;
	logic            in_accept;

	logic [7:0]                mem [VALUE_DEPTH];
	logic [7:0]                rd_data_s1;
	logic                      pend_s1, pend_n;
	logic [kvx_pkg::LEN_W-1:0] pidx_s1, pidx_n;
	logic [kvx_pkg::LEN_W-1:0] rd_addr;
	logic [kvx_pkg::LEN_W-1:0] idx_q, idx_n;
	logic [kvx_pkg::LEN_W-1:0] emit_len_q;
	logic [1:0]                rep_q;
	logic                      out_load;
	logic                      out_fire;
	logic                      take_data;

	logic                      out_valid_q;
	logic [1:0]                status_q;
	logic [7:0]                byte_q;
	logic [kvx_pkg::LEN_W-1:0] len_q;
	logic                      last_q;

	assign item      = '{text_byte: text_byte, byte_valid: byte_valid,
		end_of_text: end_of_text};
	assign in_stall  = (state_q != kvx_pkg::S_SCAN) || scan_busy;
	assign in_accept = in_valid && !in_stall;

	assign out_valid    = out_valid_q;
	assign status       = status_q;
	assign value_byte   = byte_q;
	assign value_len    = len_q;
	assign last_result  = last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.key_low  <= '0;
			cfg_q.key_high <= '0;
			cfg_q.key_len  <= 5'd1;
			cfg_q.strict   <= 1'b1;
			cfg_q.capacity <= 7'd64;
		end else if (cfg_we) begin
			case (cfg_index)
				kvx_pkg::REG_KEY_LOW:  cfg_q.key_low  <= cfg_data;
				kvx_pkg::REG_KEY_HIGH: cfg_q.key_high <= cfg_data;
				kvx_pkg::REG_KEY_LEN:  cfg_q.key_len  <= cfg_data[4:0];
				kvx_pkg::REG_STRICT:   cfg_q.strict   <= cfg_data[0];
				kvx_pkg::REG_CAPACITY: cfg_q.capacity <= cfg_data[6:0];
				default: ;
			endcase
		end
	end

	kvx_scan #(
		.VALUE_DEPTH(VALUE_DEPTH)
	) u_scan (
		.clk   (clk),
		.arst_n(arst_n),
		.cfg   (cfg_q),
		.accept(in_accept),
		.item  (item),
		.wr    (wr),
		.run   (run),
		.busy  (scan_busy)
	);

	assign out_load  = !out_valid_q || !out_stall;
	assign take_data = pend_s1 && out_load;
	assign out_fire  = (state_q == kvx_pkg::S_EMIT && take_data) ||
		(state_q == kvx_pkg::S_REPORT && out_load);

	always_comb begin
		pend_n  = 1'b0;
		pidx_n  = pidx_s1;
		idx_n   = idx_q;
		rd_addr = idx_q;
		if (state_q == kvx_pkg::S_SCAN) begin
			idx_n = '0;
		end else if (state_q == kvx_pkg::S_EMIT) begin
			if (pend_s1 && !out_load) begin
				rd_addr = pidx_s1;
				pend_n  = 1'b1;
			end else if (idx_q < emit_len_q && !scan_busy) begin
				pend_n = 1'b1;
				pidx_n = idx_q;
				idx_n  = idx_q + 6'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr.en) mem[wr.addr[AW-1:0]] <= wr.data;
		rd_data_s1 <= mem[rd_addr[AW-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= kvx_pkg::S_SCAN;
			pend_s1     <= 1'b0;
			pidx_s1     <= '0;
			idx_q       <= '0;
			emit_len_q  <= '0;
			rep_q       <= kvx_pkg::ST_OK;
			out_valid_q <= 1'b0;
		end else begin
			pend_s1 <= pend_n;
			pidx_s1 <= pidx_n;
			idx_q   <= idx_n;
			if (out_load) out_valid_q <= out_fire;
			case (state_q)
				kvx_pkg::S_SCAN: begin
					if (in_accept && end_of_text) begin
						if (run.err != kvx_pkg::ERR_NONE) begin
							rep_q   <= run.err;
							state_q <= kvx_pkg::S_REPORT;
						end else if (!run.found) begin
							rep_q   <= kvx_pkg::ST_NOT_FOUND;
							state_q <= kvx_pkg::S_REPORT;
						end else begin
							emit_len_q <= run.kept;
							state_q    <= kvx_pkg::S_EMIT;
						end
					end
				end
				kvx_pkg::S_EMIT: begin
					if (take_data && pidx_s1 == emit_len_q - 6'd1) state_q <= kvx_pkg::S_SCAN;
				end
				kvx_pkg::S_REPORT: begin
					if (out_load) state_q <= kvx_pkg::S_SCAN;
				end
				default: state_q <= kvx_pkg::S_SCAN;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == kvx_pkg::S_EMIT && take_data) begin
			status_q <= kvx_pkg::ST_OK;
			byte_q   <= rd_data_s1;
			len_q    <= emit_len_q;
			last_q   <= (pidx_s1 == emit_len_q - 6'd1);
		end else if (state_q == kvx_pkg::S_REPORT && out_load) begin
			status_q <= rep_q;
			byte_q   <= '0;
			len_q    <= '0;
			last_q   <= 1'b1;
		end
	end

endmodule

### design/kvx_scan.sv
// Line scanner: key prefix match, value commit with held CR, error latch.
// Issues writes to the value store; depends on kvx_pkg.
`timescale 1ns / 1ps

module kvx_scan #(
	parameter int VALUE_DEPTH = 64
) (
	input  logic           clk,
	input  logic           arst_n,
	input  kvx_pkg::cfg_t  cfg,
	input  logic           accept,
	input  kvx_pkg::item_t item,
	output kvx_pkg::wr_t   wr,
	output kvx_pkg::run_t  run,
	output logic           busy
);

	localparam logic [6:0] CAP_MAX = 7'(VALUE_DEPTH);

	typedef struct packed {
		logic [1:0]                err;
		logic [1:0]                tally;
		logic [kvx_pkg::LEN_W-1:0] lcl;
		logic                      done;
	} commit_t;

	function automatic commit_t commit(input commit_t c, input logic strict,
		input logic [6:0] cap);
		commit_t r;
		r = c;
		r.done = 1'b0;
		if (c.err == kvx_pkg::ERR_NONE) begin
			if (c.lcl == '0 && strict && c.tally != 2'd0) begin
				r.err = kvx_pkg::ST_DUPLICATE;
			end else if ({1'b0, c.lcl} + 7'd1 >= cap) begin
				r.err = kvx_pkg::ST_TOO_LONG;
			end else begin
				if (c.lcl == '0 && c.tally != 2'd2) r.tally = c.tally + 2'd1;
				r.lcl  = c.lcl + 6'd1;
				r.done = 1'b1;
			end
		end
		return r;
	endfunction

	logic [4:0]                col_q, col_n;
	logic                      pm_q, pm_n;
	logic                      inv_q, inv_n;
	logic [kvx_pkg::LEN_W-1:0] lcl_q, lcl_n;
	logic                      hcr_q, hcr_n;
	logic [1:0]                tally_q, tally_n;
	logic [kvx_pkg::LEN_W-1:0] kept_q, kept_n;
	logic [1:0]                err_q, err_n;
	logic                      stop_q, stop_n;
	kvx_pkg::wr_t              wq_q, wq_n;

	logic [4:0]   eff_key;
	logic [6:0]   eff_cap;
	logic [127:0] key_all;
	logic [7:0]   key_ch;
	logic [7:0]   b;
	logic         take;
	commit_t      cur, c1, c2, fin;
	logic         w1, w2;

	assign key_all = {cfg.key_high, cfg.key_low};
	assign key_ch  = key_all[{col_q[3:0], 3'b000} +: 8];
	assign b       = item.text_byte;
	assign take    = accept && item.byte_valid && err_q == kvx_pkg::ERR_NONE && !stop_q;
	assign busy    = wq_q.en;

	always_comb begin
		eff_key = (cfg.key_len > kvx_pkg::KEY_MAX) ? kvx_pkg::KEY_MAX : cfg.key_len;
		if (cfg.capacity == 7'd0) eff_cap = 7'd1;
		else if (cfg.capacity > CAP_MAX) eff_cap = CAP_MAX;
		else eff_cap = cfg.capacity;
	end

	always_comb begin
		col_n   = col_q;
		pm_n    = pm_q;
		inv_n   = inv_q;
		lcl_n   = lcl_q;
		hcr_n   = hcr_q;
		tally_n = tally_q;
		kept_n  = kept_q;
		err_n   = err_q;
		stop_n  = stop_q;
		wr      = '0;
		wq_n    = wq_q;
		cur     = {err_q, tally_q, lcl_q, 1'b0};
		c1      = hcr_q ? commit(cur, cfg.strict, eff_cap) : cur;
		c2      = commit(c1, cfg.strict, eff_cap);
		fin     = (b == kvx_pkg::CH_CR) ? c1 : c2;
		w1      = hcr_q && c1.done;
		w2      = (b != kvx_pkg::CH_CR) && c2.done;

		if (wq_q.en) begin
			wr      = wq_q;
			wq_n.en = 1'b0;
		end

		if (take) begin
			if (b == kvx_pkg::CH_NUL || b == kvx_pkg::CH_LF) begin
				col_n  = '0;
				pm_n   = 1'b1;
				inv_n  = 1'b0;
				lcl_n  = '0;
				hcr_n  = 1'b0;
				stop_n = (b == kvx_pkg::CH_NUL);
			end else if (inv_q) begin
				hcr_n   = (b == kvx_pkg::CH_CR) && c1.err == kvx_pkg::ERR_NONE;
				err_n   = fin.err;
				tally_n = fin.tally;
				lcl_n   = fin.lcl;
				if (w1 || w2) kept_n = fin.lcl;
				if (w1) begin
					wr = '{en: 1'b1, addr: cur.lcl, data: kvx_pkg::CH_CR};
					if (w2) wq_n = '{en: 1'b1, addr: c1.lcl, data: b};
				end else if (w2) begin
					wr = '{en: 1'b1, addr: c1.lcl, data: b};
				end
			end else if (pm_q) begin
				if (col_q < eff_key) begin
					if (b != key_ch) pm_n = 1'b0;
					else col_n = col_q + 5'd1;
				end else if (b == kvx_pkg::CH_EQ) begin
					inv_n = 1'b1;
				end else begin
					pm_n = 1'b0;
				end
			end
		end

		run = '{err: err_n, found: tally_n != 2'd0, kept: kept_n};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q   <= '0;
			pm_q    <= 1'b1;
			inv_q   <= 1'b0;
			lcl_q   <= '0;
			hcr_q   <= 1'b0;
			tally_q <= '0;
			kept_q  <= '0;
			err_q   <= kvx_pkg::ERR_NONE;
			stop_q  <= 1'b0;
			wq_q    <= '0;
		end else begin
			wq_q <= wq_n;
			if (accept && item.end_of_text) begin
				col_q   <= '0;
				pm_q    <= 1'b1;
				inv_q   <= 1'b0;
				lcl_q   <= '0;
				hcr_q   <= 1'b0;
				tally_q <= '0;
				kept_q  <= '0;
				err_q   <= kvx_pkg::ERR_NONE;
				stop_q  <= 1'b0;
			end else begin
				col_q   <= col_n;
				pm_q    <= pm_n;
				inv_q   <= inv_n;
				lcl_q   <= lcl_n;
				hcr_q   <= hcr_n;
				tally_q <= tally_n;
				kept_q  <= kept_n;
				err_q   <= err_n;
				stop_q  <= stop_n;
			end
		end
	end

endmodule

### design/kvx_checker.sv
// Port-level checks for the key=value line field extractor, bound to the top.
// Depends on kvx_pkg.
`timescale 1ns / 1ps

module kvx_checker (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      in_stall,
	input logic                      out_valid,
	input logic                      out_stall,
	input logic [1:0]                status,
	input logic [7:0]                value_byte,
	input logic [kvx_pkg::LEN_W-1:0] value_len,
	input logic                      last_result
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(value_byte) && $stable(status))
		else $error("stalled result item changed");

	a_error_item: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != kvx_pkg::ST_OK |->
			last_result && value_byte == 8'd0 && value_len == '0)
		else $error("status item not a lone final zero item");

	a_ok_length: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == kvx_pkg::ST_OK |-> value_len != '0)
		else $error("ok item with zero value length");

	a_emit_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == kvx_pkg::ST_OK && !last_result |-> in_stall)
		else $error("input taken while value items remain");

endmodule

bind key_value_line_field_extractor kvx_checker u_kvx_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_stall    (in_stall),
	.out_valid   (out_valid),
	.out_stall   (out_stall),
	.status      (status),
	.value_byte  (value_byte),
	.value_len   (value_len),
	.last_result (last_result)
);

### dv/tb.sv
// Self-checking testbench for key_value_line_field_extractor.
// Drives text items and register writes, predicts every result in a small
// scoreboard class and compares it field by field. Depends on kvx_pkg and the RTL.
`timescale 1ns / 1ps

module tb;

	typedef struct packed {
		logic [1:0]                status;
		logic [7:0]                vbyte;
		logic [kvx_pkg::LEN_W-1:0] vlen;
		logic                      last;
	} value_result_t;

	class value_scoreboard;
		logic [63:0]   key_lo;
		logic [63:0]   key_hi;
		logic [4:0]    key_len;
		logic          strict;
		logic [6:0]    cap;
		logic [7:0]    store [64];
		int            col;
		bit            prefix_ok;
		bit            in_value;
		int            line_len;
		bit            held_cr;
		int            tally;
		int            kept_len;
		logic [1:0]    err;
		bit            stopped;
		int            fails;
		value_result_t pending_values [$];

		function new();
			key_lo = '0;
			key_hi = '0;
			key_len = 5'd1;
			strict = 1'b1;
			cap = 7'd64;
			fails = 0;
			clear_run();
		endfunction

		function void clear_line();
			col = 0;
			prefix_ok = 1;
			in_value = 0;
			line_len = 0;
			held_cr = 0;
		endfunction

		function void clear_run();
			clear_line();
			tally = 0;
			kept_len = 0;
			err = kvx_pkg::ERR_NONE;
			stopped = 0;
		endfunction

		function void set_reg(logic [kvx_pkg::CFG_IDX_W-1:0] idx, logic [63:0] d);
			case (idx)
				kvx_pkg::REG_KEY_LOW:  key_lo = d;
				kvx_pkg::REG_KEY_HIGH: key_hi = d;
				kvx_pkg::REG_KEY_LEN:  key_len = d[4:0];
				kvx_pkg::REG_STRICT:   strict = d[0];
				kvx_pkg::REG_CAPACITY: cap = d[6:0];
				default: ;
			endcase
		endfunction

		function int pending();
			return pending_values.size();
		endfunction

		function int eff_key_len();
			return (key_len > kvx_pkg::KEY_MAX) ? kvx_pkg::KEY_MAX : key_len;
		endfunction

		function int eff_cap();
			if (cap == 0)
				return 1;
			return (cap > 64) ? 64 : cap;
		endfunction

		function logic [7:0] key_char(int idx);
			logic [63:0] w;
			w = idx[3] ? key_hi : key_lo;
			return w[idx[2:0]*8 +: 8];
		endfunction

		function void commit_byte(logic [7:0] b);
			if (err != kvx_pkg::ERR_NONE)
				return;
			if (line_len == 0 && strict && tally >= 1) begin
				err = kvx_pkg::ST_DUPLICATE;
				return;
			end
			if (line_len + 1 >= eff_cap()) begin
				err = kvx_pkg::ST_TOO_LONG;
				return;
			end
			if (line_len == 0 && tally < 2)
				tally++;
			store[line_len & 63] = b;
			line_len++;
			kept_len = line_len;
		endfunction

		function void scan_byte(logic [7:0] b);
			if (b == kvx_pkg::CH_NUL) begin
				clear_line();
				stopped = 1;
				return;
			end
			if (b == kvx_pkg::CH_LF) begin
				clear_line();
				return;
			end
			if (in_value) begin
				if (held_cr) begin
					held_cr = 0;
					commit_byte(kvx_pkg::CH_CR);
					if (err != kvx_pkg::ERR_NONE)
						return;
				end
				if (b == kvx_pkg::CH_CR)
					held_cr = 1;
				else
					commit_byte(b);
				return;
			end
			if (!prefix_ok)
				return;
			if (col < eff_key_len()) begin
				if (b != key_char(col))
					prefix_ok = 0;
				else
					col++;
			end else if (b == kvx_pkg::CH_EQ) begin
				in_value = 1;
			end else begin
				prefix_ok = 0;
			end
		endfunction

		function void take_item(logic [7:0] b, logic bv, logic eot);
			value_result_t r;
			int n;
			int i;
			if (bv && err == kvx_pkg::ERR_NONE && !stopped)
				scan_byte(b);
			if (!eot)
				return;
			if (err != kvx_pkg::ERR_NONE || tally == 0) begin
				r.status = (err != kvx_pkg::ERR_NONE) ? err : kvx_pkg::ST_NOT_FOUND;
				r.vbyte = '0;
				r.vlen = '0;
				r.last = 1'b1;
				pending_values.push_back(r);
			end else begin
				n = (kept_len > 63) ? 63 : kept_len;
				for (i = 0; i < n; i++) begin
					r.status = kvx_pkg::ST_OK;
					r.vbyte = store[i];
					r.vlen = n[kvx_pkg::LEN_W-1:0];
					r.last = (i == n - 1);
					pending_values.push_back(r);
				end
			end
			clear_run();
		endfunction

		function void check_result(logic [1:0] st, logic [7:0] vb,
				logic [kvx_pkg::LEN_W-1:0] vl, logic lr);
			value_result_t e;
			if (pending_values.size() == 0) begin
				fails++;
				if (fails <= 10)
					$display("unexpected result: status %0d byte %02h length %0d last %0b",
						st, vb, vl, lr);
				return;
			end
			e = pending_values.pop_front();
			if (e.status !== st || e.vbyte !== vb || e.vlen !== vl || e.last !== lr) begin
				fails++;
				if (fails <= 10)
					$display("mismatch (exp/got): status %0d/%0d byte %02h/%02h length %0d/%0d last %0b/%0b",
						e.status, st, e.vbyte, vb, e.vlen, vl, e.last, lr);
			end
		endfunction
	endclass

	logic                          clk;
	logic                          arst_n;
	logic                          cfg_we;
	logic [kvx_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [63:0]                   cfg_data;
	logic                          in_valid;
	logic                          in_stall;
	logic [7:0]                    text_byte;
	logic                          byte_valid;
	logic                          end_of_text;
	logic                          out_valid;
	logic                          out_stall;
	logic [1:0]                    status;
	logic [7:0]                    value_byte;
	logic [kvx_pkg::LEN_W-1:0]     value_len;
	logic                          last_result;

	value_scoreboard sb;
	logic [63:0]     key_lo;
	logic [63:0]     key_hi;
	int              eff_klen;
	int              eff_cap;
	int              items_sent;
	logic [7:0]      text_q [$];
	bit              quiet;
	int              stall_left;

	key_value_line_field_extractor u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.text_byte    (text_byte),
		.byte_valid   (byte_valid),
		.end_of_text  (end_of_text),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.status       (status),
		.value_byte   (value_byte),
		.value_len    (value_len),
		.last_result  (last_result)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall)
				sb.take_item(text_byte, byte_valid, end_of_text);
			if (out_valid && !out_stall)
				sb.check_result(status, value_byte, value_len, last_result);
		end
	end

	// hold the output side in random bursts
	always @(posedge clk) begin
		if (stall_left != 0) begin
			stall_left <= stall_left - 1;
			out_stall <= 1'b1;
		end else if (!quiet && $urandom_range(0, 9) == 0) begin
			stall_left <= $urandom_range(0, 16);
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	function automatic logic [7:0] key_byte(int idx);
		logic [63:0] w;
		w = idx[3] ? key_hi : key_lo;
		return w[idx[2:0]*8 +: 8];
	endfunction

	function automatic logic [7:0] value_char();
		int r;
		r = $urandom_range(0, 63);
		if (r == 0)
			return kvx_pkg::CH_NUL;
		if (r < 8)
			return kvx_pkg::CH_CR;
		if (r == 8)
			return kvx_pkg::CH_EQ;
		if (r < 16)
			return 8'($urandom_range(128, 255));
		return 8'($urandom_range(32, 126));
	endfunction

	task automatic send_item(logic [7:0] b, logic bv, logic eot);
		if (!quiet && $urandom_range(0, 7) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 17)) @(posedge clk);
		end
		in_valid <= 1'b1;
		text_byte <= b;
		byte_valid <= bv;
		end_of_text <= eot;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		items_sent++;
	endtask

	task automatic send_run(bit eot_on_byte);
		int n;
		int i;
		n = text_q.size();
		for (i = 0; i < n; i++) begin
			if ($urandom_range(0, 19) == 0)
				send_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
			send_item(text_q[i], 1'b1, eot_on_byte && i == n - 1);
		end
		if (!eot_on_byte || n == 0)
			send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
	endtask

	task automatic push_key_eq();
		int i;
		for (i = 0; i < eff_klen; i++)
			text_q.push_back(key_byte(i));
		text_q.push_back(kvx_pkg::CH_EQ);
	endtask

	task automatic add_line();
		int kind;
		int n;
		int pos;
		int i;
		logic [7:0] flip;
		kind = $urandom_range(0, 9);
		if (kind < 6) begin
			push_key_eq();
			n = ($urandom_range(0, 7) == 0) ? $urandom_range(0, eff_cap + 1)
				: $urandom_range(0, 6);
			for (i = 0; i < n; i++)
				text_q.push_back(value_char());
			if ($urandom_range(0, 2) == 0)
				text_q.push_back(kvx_pkg::CH_CR);
		end else if (kind < 8) begin
			// near miss: one key character or the '=' is wrong
			pos = $urandom_range(0, eff_klen);
			flip = 8'($urandom_range(1, 255));
			for (i = 0; i < eff_klen; i++)
				text_q.push_back((i == pos) ? key_byte(i) ^ flip : key_byte(i));
			text_q.push_back((pos == eff_klen) ? kvx_pkg::CH_EQ ^ flip : kvx_pkg::CH_EQ);
			n = $urandom_range(0, 4);
			for (i = 0; i < n; i++)
				text_q.push_back(value_char());
		end else begin
			n = $urandom_range(1, 8);
			for (i = 0; i < n; i++)
				text_q.push_back(8'($urandom_range(0, 255)));
		end
		if ($urandom_range(0, 5) != 0)
			text_q.push_back(kvx_pkg::CH_LF);
	endtask

	task automatic random_run();
		text_q.delete();
		repeat ($urandom_range(1, 4))
			add_line();
		send_run(1'($urandom_range(0, 1)));
	endtask

	task automatic write_reg(logic [kvx_pkg::CFG_IDX_W-1:0] idx, logic [63:0] d);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= d;
		sb.set_reg(idx, d);
		@(posedge clk);
	endtask

	task automatic setup_phase(int klen, bit strict_on, int cap);
		logic [63:0] d;
		int i;
		key_lo = {$urandom, $urandom};
		key_hi = {$urandom, $urandom};
		for (i = 0; i < 8; i++) begin
			if (key_lo[i*8 +: 8] == kvx_pkg::CH_LF || key_lo[i*8 +: 8] == kvx_pkg::CH_NUL)
				key_lo[i*8 +: 8] = "K";
			if (key_hi[i*8 +: 8] == kvx_pkg::CH_LF || key_hi[i*8 +: 8] == kvx_pkg::CH_NUL)
				key_hi[i*8 +: 8] = "K";
		end
		write_reg(kvx_pkg::REG_KEY_LOW, key_lo);
		write_reg(kvx_pkg::REG_KEY_HIGH, key_hi);
		d = {$urandom, $urandom};
		d[4:0] = klen[4:0];
		write_reg(kvx_pkg::REG_KEY_LEN, d);
		d = {$urandom, $urandom};
		d[0] = strict_on;
		write_reg(kvx_pkg::REG_STRICT, d);
		d = {$urandom, $urandom};
		d[6:0] = cap[6:0];
		write_reg(kvx_pkg::REG_CAPACITY, d);
		cfg_we <= 1'b0;
		eff_klen = (klen > kvx_pkg::KEY_MAX) ? kvx_pkg::KEY_MAX : klen;
		eff_cap = (cap == 0) ? 1 : ((cap > 64) ? 64 : cap);
	endtask

	// stop sending, wait for every result, then let the block settle
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	initial begin
		int p;
		int i;
		int klen;
		int cap;
		bit strict_on;
		clk = 1'b0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_valid = 1'b0;
		text_byte = '0;
		byte_valid = 1'b0;
		end_of_text = 1'b0;
		out_stall = 1'b0;
		stall_left = 0;
		quiet = 0;
		items_sent = 0;
		sb = new();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// writes past the last register must be ignored
		for (i = kvx_pkg::REG_CAPACITY + 1; i < (1 << kvx_pkg::CFG_IDX_W); i++)
			write_reg(i[kvx_pkg::CFG_IDX_W-1:0], {$urandom, $urandom});
		setup_phase(2, 1'b1, 64);

		// held CRs inside the value, end of text carrying a byte
		text_q.delete();
		push_key_eq();
		text_q.push_back("v");
		text_q.push_back(kvx_pkg::CH_CR);
		text_q.push_back(kvx_pkg::CH_CR);
		text_q.push_back("z");
		send_run(1'b1);
		// empty value after CR drop, then a second match in strict mode
		text_q.delete();
		push_key_eq();
		text_q.push_back(kvx_pkg::CH_CR);
		text_q.push_back(kvx_pkg::CH_LF);
		push_key_eq();
		text_q.push_back("1");
		text_q.push_back(kvx_pkg::CH_LF);
		push_key_eq();
		text_q.push_back("2");
		send_run(1'b0);
		// zero byte stops the scan; an empty item does nothing
		send_item(8'h00, 1'b0, 1'b0);
		text_q.delete();
		text_q.push_back(8'hFF);
		text_q.push_back(kvx_pkg::CH_NUL);
		push_key_eq();
		text_q.push_back("q");
		send_run(1'b0);

		for (p = 0; p < 8; p++) begin
			case (p)
				0: begin
					klen = 0;
					cap = 64;
				end
				1: begin
					klen = 16;
					cap = 0;
				end
				2: begin
					klen = 31;
					cap = 127;
				end
				3: begin
					klen = 1;
					cap = 1;
				end
				4: begin
					klen = $urandom_range(1, 16);
					cap = 2;
				end
				default: begin
					klen = $urandom_range(1, 16);
					cap = $urandom_range(0, 1) ? 64 : $urandom_range(3, 12);
				end
			endcase
			strict_on = (p < 2) ? p[0] : 1'($urandom_range(0, 1));
			quiet = (p == 7) || ($urandom_range(0, 4) == 0);
			drain();
			setup_phase(klen, strict_on, cap);
			while (items_sent < (p + 1) * 54)
				random_run();
		end
		drain();

		if (sb.fails == 0 && sb.pending() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

	initial begin
		#25_000_000;
		$display("simulation failed");
		$finish;
	end

endmodule
